// File: src/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types, constants and helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned OUT_DW  = 40;  // code_point + sequence_bytes, padded to bytes

    // Register map (byte addresses)
    localparam logic [APB_AW-1:0] ADDR_MAX_SEQ = 3'h0;

    localparam logic [LEN_W-1:0] MAX_SEQ_RESET = 3'd6;
    localparam logic [LEN_W-1:0] SEQ_MIN       = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_MAX       = 3'd6;
    localparam logic [LEN_W-1:0] LEN_ONE       = 3'd1;

    localparam logic [BYTE_W-1:0] LEAD_PAYLOAD = 8'h7F;

    typedef enum logic [1:0] {
        SKIP_NONE = 2'd0,
        SKIP_CONT = 2'd1,
        SKIP_FEFF = 2'd2
    } skip_t;

    // Length of the sequence a lead byte 11xxxxxx (below 0xFE) announces.
    function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] n;
        begin
            if ((b & 8'hE0) == 8'hC0)
                n = 3'd2;
            else if ((b & 8'hF0) == 8'hE0)
                n = 3'd3;
            else if ((b & 8'hF8) == 8'hF0)
                n = 3'd4;
            else if ((b & 8'hFC) == 8'hF8)
                n = 3'd5;
            else
                n = 3'd6;
            return n;
        end
    endfunction

    // Clamp the configured limit into 2..6.
    function automatic logic [LEN_W-1:0] clamp_limit(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        begin
            if (v < SEQ_MIN)
                r = SEQ_MIN;
            else if (v > SEQ_MAX)
                r = SEQ_MAX;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

// File: src/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with a configurable maximum sequence length.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_ channel, one per beat (s_tdata[7:0]). Each
//   completed sequence, each one-byte character and each malformed byte
//   leaves as one beat on the m_ channel: m_tdata carries the code point
//   and the sequence length, m_tuser flags a malformed result. Bytes in the
//   middle of a sequence and skipped bytes give no output beat.
//   The APB port holds max_sequence_bytes at address 0x0 (reset value 6,
//   values 0 and 1 act as 2, 7 acts as 6). Write it only while idle.
// Timing:
//   A byte is captured in the input register, decoded combinationally from
//   there, and its result lands in the output register. One byte per cycle
//   is sustained while m_tready stays high; the single decode stage between
//   the two registers sets that rate.
// Reset:
//   Clears both pipeline valids, the decoder state and restores the limit.
// Stall:
//   While m_tready is low and a result waits, the decode stage holds and
//   s_tready drops once the input register is also full; nothing is lost.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [u8sd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [u8sd_pkg::OUT_DW-1:0]     m_tdata,   // [30:0] code_point, [33:31] sequence_bytes, [39:34] zero
    output logic                            m_tuser,   // [0] malformed
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8sd_pkg::APB_AW-1:0]     paddr,
    input  logic [u8sd_pkg::APB_DW-1:0]     pwdata,
    output logic [u8sd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import u8sd_pkg::*;

    // configuration
    logic [LEN_W-1:0]  max_seq_reg;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // decoder state
    logic [CP_W-1:0]   acc_reg,  acc_next;
    logic [LEN_W-1:0]  rem_reg,  rem_next;
    logic [LEN_W-1:0]  slen_reg, slen_next;
    skip_t             skip_reg, skip_next;

    // output stage
    logic              out_valid_reg;
    logic [CP_W-1:0]   cp_reg,   cp_next;
    logic              bad_reg,  bad_next;
    logic [LEN_W-1:0]  len_reg,  len_next;
    logic              emit;

    logic              advance;
    logic              cfg_wr;
    logic [LEN_W-1:0]  limit;
    logic [LEN_W-1:0]  lead_n;
    logic [BYTE_W-1:0] lead_mask;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_MAX_SEQ[2]);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_MAX_SEQ[2])
        begin
            prdata[LEN_W-1:0] = max_seq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seq_reg <= MAX_SEQ_RESET;
        end
        else if (cfg_wr)
        begin
            max_seq_reg <= pwdata[LEN_W-1:0];
        end
    end

    // ---------------------------------------------------------- handshake
    // The decode stage moves whenever the output register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // -------------------------------------------------------------- decode
    assign limit     = clamp_limit(max_seq_reg);
    assign lead_n    = lead_length(in_byte_reg);
    assign lead_mask = LEAD_PAYLOAD >> lead_n;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        slen_next = slen_reg;
        skip_next = skip_reg;
        emit      = 1'b0;
        cp_next   = '0;
        bad_next  = 1'b0;
        len_next  = LEN_ONE;

        if (rem_reg != '0)
        begin
            // Absorb any byte as a continuation; only its low six bits count.
            acc_next = {acc_reg[CP_W-7:0], in_byte_reg[5:0]};
            rem_next = rem_reg - LEN_ONE;
            if (rem_reg == LEN_ONE)
            begin
                emit     = 1'b1;
                cp_next  = {acc_reg[CP_W-7:0], in_byte_reg[5:0]};
                len_next = slen_reg;
            end
        end
        else if ((skip_reg == SKIP_CONT) && (in_byte_reg[7:6] == 2'b10))
        begin
            // drop continuation run
        end
        else if ((skip_reg == SKIP_FEFF) && (in_byte_reg[7:1] == 7'h7F))
        begin
            // drop 0xFE/0xFF run
        end
        else
        begin
            skip_next = SKIP_NONE;
            if (!in_byte_reg[7])
            begin
                emit    = 1'b1;
                cp_next = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg};
            end
            else if (in_byte_reg[6] == 1'b0)
            begin
                // stray continuation
                emit      = 1'b1;
                bad_next  = 1'b1;
                skip_next = SKIP_CONT;
            end
            else if (in_byte_reg[7:1] == 7'h7F)
            begin
                emit      = 1'b1;
                bad_next  = 1'b1;
                skip_next = SKIP_FEFF;
            end
            else if (lead_n > limit)
            begin
                // oversized lead: flag it and skip its continuation bytes
                emit      = 1'b1;
                bad_next  = 1'b1;
                skip_next = SKIP_CONT;
            end
            else
            begin
                acc_next  = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg & lead_mask};
                slen_next = lead_n;
                rem_next  = lead_n - LEN_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            rem_reg       <= '0;
            slen_reg      <= '0;
            skip_reg      <= SKIP_NONE;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && emit;
            if (in_valid_reg)
            begin
                acc_reg  <= acc_next;
                rem_reg  <= rem_next;
                slen_reg <= slen_next;
                skip_reg <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && emit)
        begin
            cp_reg  <= cp_next;
            bad_reg <= bad_next;
            len_reg <= len_next;
        end
    end

    // -------------------------------------------------------------- output
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DW-CP_W-LEN_W){1'b0}}, len_reg, cp_reg};
    assign m_tuser  = bad_reg;

    // ---------------------------------------------------------- assertions
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (cp_reg == '0 && len_reg == LEN_ONE))
        else $error("malformed result carries data");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < SEQ_MAX)
        else $error("bytes remaining out of range");

    a_no_skip_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> (skip_reg == SKIP_NONE))
        else $error("skip mode active inside a sequence");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (len_reg >= LEN_ONE && len_reg <= SEQ_MAX))
        else $error("sequence length out of range");

endmodule

// File: tb/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the byte-serial UTF-8 decoder. A queue of stream
// bytes feeds a clocked driver on the s_ side. A clocked monitor decodes
// every accepted byte with its own model of the decoder and compares each
// m_ beat with the oldest predicted character. The limit register is
// rewritten between idle phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8sd_pkg::*;

    // One decoded character as it leaves the m_ side.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             malformed;
        logic [LEN_W-1:0] sequence_bytes;
    } char_result_t;

    // Limit settings for the random segments: extremes, out-of-range values
    // and everything in between.
    localparam int unsigned SEG_COUNT = 12;
    localparam logic [LEN_W-1:0] CFG_PLAN [SEG_COUNT] =
        '{3'd2, 3'd6, 3'd1, 3'd7, 3'd3, 3'd0, 3'd4, 3'd5, 3'd6, 3'd2, 3'd5, 3'd7};
    localparam int unsigned SEG_BYTES   = 117;
    localparam int unsigned DRAIN_WAIT  = 8;       // pipeline is two stages deep
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;     // [7:0] in_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;           // [30:0] code_point, [33:31] sequence_bytes
    logic                m_tuser;           // [0] malformed
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Bytes waiting for the driver, characters waiting for the m_ side.
    logic [BYTE_W-1:0]   byte_queue[$];
    char_result_t        expected_chars[$];

    // Decoder model state and its copy of the limit register.
    logic [CP_W-1:0]     acc        = '0;
    logic [LEN_W-1:0]    cont_left  = '0;
    logic [LEN_W-1:0]    seq_len    = '0;
    skip_t               skip_state = SKIP_NONE;
    logic [LEN_W-1:0]    max_seq_cfg = MAX_SEQ_RESET;

    int unsigned         send_idle_pct  = 13;
    int unsigned         recv_stall_pct = 45;
    int unsigned         fail_count     = 0;
    int unsigned         cycle_count    = 0;
    bit                  byte_taken     = 1'b0;

    utf8_stream_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    function automatic char_result_t make_char(input logic [CP_W-1:0] cp, input logic bad,
                                               input logic [LEN_W-1:0] len);
        char_result_t r;
        r.code_point     = cp;
        r.malformed      = bad;
        r.sequence_bytes = len;
        return r;
    endfunction

    // Advance the decoder model by one byte and queue the character it
    // completes, if any.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] limit;
        logic [LEN_W-1:0] n;
        limit = (max_seq_cfg < 3'd2) ? 3'd2 : (max_seq_cfg > 3'd6) ? 3'd6 : max_seq_cfg;

        // Inside a sequence every byte counts as a continuation, whatever it is.
        if (cont_left != '0)
        begin
            acc       = {acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == '0)
                expected_chars.push_back(make_char(acc, 1'b0, seq_len));
            return;
        end

        // Drop bytes of the kind being skipped; anything else ends the skip.
        if (skip_state == SKIP_CONT && b[7:6] == 2'b10)
            return;
        if (skip_state == SKIP_FEFF && b >= 8'hFE)
            return;
        skip_state = SKIP_NONE;

        if (!b[7])
            expected_chars.push_back(make_char(CP_W'(b), 1'b0, LEN_ONE));
        else if (b[7:6] == 2'b10)
        begin
            skip_state = SKIP_CONT;
            expected_chars.push_back(make_char('0, 1'b1, LEN_ONE));
        end
        else if (b >= 8'hFE)
        begin
            skip_state = SKIP_FEFF;
            expected_chars.push_back(make_char('0, 1'b1, LEN_ONE));
        end
        else
        begin
            casez (b)
                8'b110?????: n = 3'd2;
                8'b1110????: n = 3'd3;
                8'b11110???: n = 3'd4;
                8'b111110??: n = 3'd5;
                default:     n = 3'd6;
            endcase
            if (n > limit)
            begin
                // Lead too long for the current limit: flag it, then skip its tail.
                skip_state = SKIP_CONT;
                expected_chars.push_back(make_char('0, 1'b1, LEN_ONE));
            end
            else
            begin
                acc       = CP_W'(b & (8'h7F >> n));
                seq_len   = n;
                cont_left = n - 3'd1;
            end
        end
    endtask

    // Append one group of stream bytes: mostly well-formed characters with
    // random payload, plus stray continuations, 0xFE/0xFF runs and noise.
    task automatic push_random_group();
        int unsigned kind;
        int unsigned n;
        logic [BYTE_W-1:0] lead;
        kind = $urandom_range(99);
        if (kind < 35)
            byte_queue.push_back(8'($urandom_range(8'h7F)));
        else if (kind < 75)
        begin
            n = $urandom_range(6, 2);
            case (n)
                2:       lead = 8'hC0 | 8'($urandom_range(8'h1F));
                3:       lead = 8'hE0 | 8'($urandom_range(8'h0F));
                4:       lead = 8'hF0 | 8'($urandom_range(8'h07));
                5:       lead = 8'hF8 | 8'($urandom_range(8'h03));
                default: lead = 8'hFC | 8'($urandom_range(8'h01));
            endcase
            byte_queue.push_back(lead);
            repeat (n - 1)
                byte_queue.push_back(8'h80 | 8'($urandom_range(8'h3F)));
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(3, 1))
                byte_queue.push_back(8'h80 | 8'($urandom_range(8'h3F)));
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(3, 1))
                byte_queue.push_back(8'hFE | 8'($urandom_range(1)));
        end
        else
            byte_queue.push_back(8'($urandom_range(8'hFF)));
    endtask

    // Hold the stream until every byte is in and every character is out, then
    // give the pipeline time to finish bytes that produce nothing.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // APB write of the limit register: setup beat, then access beat.
    task automatic write_max_seq(input logic [LEN_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_MAX_SEQ;
        pwdata  <= APB_DW'(v);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        max_seq_cfg = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Driver: advance to the next queued byte once the current beat is taken,
    // or hold valid low for a random idle cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || byte_taken)
        begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_queue.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall at random.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Monitor: check each result beat against the oldest prediction, then
    // feed the model with the byte accepted on this edge.
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected result beat: code_point %0h malformed %0b",
                           m_tdata[CP_W-1:0], m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.code_point)
                    begin
                        $error("code_point mismatch: expected %0h, actual %0h",
                               want.code_point, m_tdata[CP_W-1:0]);
                        fail_count++;
                    end
                    if (m_tuser !== want.malformed)
                    begin
                        $error("malformed mismatch: expected %0b, actual %0b",
                               want.malformed, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[CP_W +: LEN_W] !== want.sequence_bytes)
                    begin
                        $error("sequence_bytes mismatch: expected %0d, actual %0d",
                               want.sequence_bytes, m_tdata[CP_W +: LEN_W]);
                        fail_count++;
                    end
                end
            end
            byte_taken = s_tvalid && s_tready;
            if (byte_taken)
                decode_byte(s_tdata);
        end
        else
            byte_taken = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int unsigned seg;
        int unsigned start_len;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset limit of 6: zero byte and 0x7F, a two-byte char,
        // a three-byte char with ASCII and 0xFF absorbed mid-sequence, a
        // four-byte emoji, a full six-byte char, a stray continuation with
        // its skipped tail, an FE/FF run closed by a stray continuation, and
        // a three-byte lead left open across the register write below.
        byte_queue = '{8'h00, 8'h7F, 8'hC3, 8'hBF, 8'hEF, 8'h41, 8'hFF,
                       8'hF0, 8'h9F, 8'h98, 8'h80,
                       8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                       8'h80, 8'hBF, 8'hFE, 8'hFF, 8'h80, 8'hE4};
        wait_drained();

        // Limit 4: the open sequence still ends as three bytes, then a
        // five-byte lead is oversized and its continuations are skipped.
        write_max_seq(3'd4);
        byte_queue = '{8'hB8, 8'h80, 8'hF8, 8'h80, 8'hBF, 8'hC2, 8'h80};
        wait_drained();

        // Random segments, each at its own limit. Idle the sender lightly and
        // the receiver heavily first, then swap, then run without idling.
        for (seg = 0; seg < SEG_COUNT; seg++)
        begin
            if (seg == SEG_COUNT / 3)
            begin
                send_idle_pct  = 45;
                recv_stall_pct = 13;
            end
            else if (seg == 2 * SEG_COUNT / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_max_seq(CFG_PLAN[seg]);
            start_len = 0;
            while (start_len < SEG_BYTES)
            begin
                push_random_group();
                start_len = byte_queue.size();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
src/u8sd_pkg.sv
src/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
